@@ rtl/qpve_pkg.sv @@
// ----------------------------------------------------------------------------
// qpve_pkg
// Shared types, character codes and helpers for the query parameter value
// extractor.
// ----------------------------------------------------------------------------
package qpve_pkg;

  localparam int MAX_KEY_BYTES_DEF = 8;
  localparam int OUT_DEPTH_DEF     = 4;

  // Characters of the query syntax
  localparam logic [7:0] CH_AMP     = 8'h26;  // '&'
  localparam logic [7:0] CH_EQUALS  = 8'h3D;  // '='
  localparam logic [7:0] CH_PLUS    = 8'h2B;  // '+'
  localparam logic [7:0] CH_PERCENT = 8'h25;  // '%'
  localparam logic [7:0] CH_COMMA   = 8'h2C;  // ','
  localparam logic [7:0] CH_SPACE   = 8'h20;  // ' '
  localparam logic [7:0] CH_ZERO    = 8'h30;  // '0'
  localparam logic [7:0] CH_NINE    = 8'h39;  // '9'
  localparam logic [7:0] CH_UPPER_A = 8'h41;  // 'A'
  localparam logic [7:0] CH_UPPER_F = 8'h46;  // 'F'

  // Configuration register indexes
  localparam logic [1:0] REG_KEY_TEXT   = 2'd0;
  localparam logic [1:0] REG_KEY_LENGTH = 2'd1;
  localparam logic [1:0] REG_INSTANCE   = 2'd2;

  // Result kinds and status codes
  localparam logic       KIND_BYTE   = 1'b0;
  localparam logic       KIND_STATUS = 1'b1;
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND  = 2'd1;
  localparam logic [1:0] ST_BAD_ESCAPE = 2'd2;

  typedef enum logic [1:0] {
    PH_KEY   = 2'd0,
    PH_VALUE = 2'd1,
    PH_SKIP  = 2'd2
  } phase_t;

  typedef enum logic [1:0] {
    ESC_NONE = 2'd0,
    ESC_HIGH = 2'd1,
    ESC_LOW  = 2'd2
  } escape_step_t;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       end_of_string;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_kind;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // Up to two results raised by one accepted transaction
  typedef struct packed {
    logic [1:0] count;
    out_item_t  first;
    out_item_t  second;
  } push_t;

  // Uppercase hex digit: {valid, nibble}
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    d = 8'd0;
    if (c >= CH_ZERO && c <= CH_NINE) begin
      d = c - CH_ZERO;
      return {1'b1, d[3:0]};
    end
    if (c >= CH_UPPER_A && c <= CH_UPPER_F) begin
      d = c - CH_UPPER_A + 8'd10;
      return {1'b1, d[3:0]};
    end
    return 5'd0;
  endfunction

  function automatic out_item_t byte_item(input logic [7:0] b);
    out_item_t r;
    r.out_byte = b;
    r.out_kind = KIND_BYTE;
    r.status   = ST_OK;
    r.last     = 1'b0;
    return r;
  endfunction

endpackage

@@ rtl/qpve_parser.sv @@
// ----------------------------------------------------------------------------
// qpve_parser
// Per-byte field matcher and value decoder; raises up to two results per
// transaction.
// ----------------------------------------------------------------------------
module qpve_parser
  import qpve_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       accept,
  input  in_item_t                   in_data,
  input  logic [8*MAX_KEY_BYTES-1:0] key_text,
  input  logic [3:0]                 key_length,
  input  logic [7:0]                 instance_cfg,
  output push_t                      push
);

  localparam logic [3:0] KLEN_MAX = 4'(MAX_KEY_BYTES);

  phase_t       phase, phase_next;
  logic [3:0]   match_position, match_position_next;
  logic [7:0]   matches_seen, matches_seen_next;
  escape_step_t escape_step, escape_step_next;
  logic [3:0]   high_nibble, high_nibble_next;
  logic         emitted_any, emitted_any_next;
  logic         escape_error, escape_error_next;

  logic [3:0] klen;
  logic [7:0] key_byte;
  logic [4:0] hex;
  logic [7:0] c;
  logic       sel;
  logic       err;
  out_item_t  status_item;

  assign c    = in_data.in_byte;
  assign klen = (key_length > KLEN_MAX) ? KLEN_MAX : key_length;
  assign hex  = hex_digit(c);

  always_comb begin
    key_byte = 8'd0;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (match_position == 4'(i)) begin
        key_byte = key_text[8*i +: 8];
      end
    end
  end

  always_comb begin
    phase_next          = phase;
    match_position_next = match_position;
    matches_seen_next   = matches_seen;
    escape_step_next    = escape_step;
    high_nibble_next    = high_nibble;
    emitted_any_next    = emitted_any;
    escape_error_next   = escape_error;
    push                = '0;
    sel                 = 1'b0;
    err                 = escape_error;
    status_item         = '0;

    if (accept) begin
      if (in_data.end_of_string) begin
        if (phase == PH_VALUE && escape_step != ESC_NONE) begin
          err = 1'b1;
        end
        status_item.out_kind = KIND_STATUS;
        status_item.last     = 1'b1;
        status_item.status   = err ? ST_BAD_ESCAPE : (emitted_any ? ST_OK : ST_NOT_FOUND);
        push.count           = 2'd1;
        push.first           = status_item;
        phase_next           = PH_KEY;
        match_position_next  = 4'd0;
        matches_seen_next    = 8'd0;
        escape_step_next     = ESC_NONE;
        high_nibble_next     = 4'd0;
        emitted_any_next     = 1'b0;
        escape_error_next    = 1'b0;
      end else if (c == CH_AMP) begin
        if (phase == PH_VALUE && escape_step != ESC_NONE) begin
          escape_error_next = 1'b1;
        end
        phase_next          = PH_KEY;
        match_position_next = 4'd0;
        escape_step_next    = ESC_NONE;
      end else begin
        case (phase)
          PH_KEY: begin
            if (match_position < klen) begin
              if (c == key_byte) begin
                match_position_next = match_position + 4'd1;
              end else begin
                phase_next = PH_SKIP;
              end
            end else if (c == CH_EQUALS) begin
              if (instance_cfg == 8'd0) begin
                sel = 1'b1;
                if (matches_seen != 8'hFF) begin
                  matches_seen_next = matches_seen + 8'd1;
                end
              end else if (matches_seen != 8'hFF) begin
                matches_seen_next = matches_seen + 8'd1;
                sel = (matches_seen + 8'd1 == instance_cfg);
              end
              if (sel) begin
                if (instance_cfg == 8'd0 && emitted_any) begin
                  push.count  = 2'd2;
                  push.first  = byte_item(CH_COMMA);
                  push.second = byte_item(CH_SPACE);
                end
                emitted_any_next = 1'b1;
                phase_next       = PH_VALUE;
                escape_step_next = ESC_NONE;
              end else begin
                phase_next = PH_SKIP;
              end
            end else begin
              phase_next = PH_SKIP;
            end
          end
          PH_VALUE: begin
            case (escape_step)
              ESC_HIGH: begin
                if (!hex[4]) begin
                  escape_error_next = 1'b1;
                  escape_step_next  = ESC_NONE;
                end else begin
                  high_nibble_next = hex[3:0];
                  escape_step_next = ESC_LOW;
                end
              end
              ESC_LOW: begin
                if (!hex[4]) begin
                  escape_error_next = 1'b1;
                end else begin
                  push.count = 2'd1;
                  push.first = byte_item({high_nibble, hex[3:0]});
                end
                escape_step_next = ESC_NONE;
              end
              default: begin
                if (c == CH_PERCENT) begin
                  escape_step_next = ESC_HIGH;
                end else begin
                  push.count = 2'd1;
                  push.first = byte_item((c == CH_PLUS) ? CH_SPACE : c);
                end
              end
            endcase
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_KEY;
      match_position <= 4'd0;
      matches_seen   <= 8'd0;
      escape_step    <= ESC_NONE;
      high_nibble    <= 4'd0;
      emitted_any    <= 1'b0;
      escape_error   <= 1'b0;
    end else begin
      phase          <= phase_next;
      match_position <= match_position_next;
      matches_seen   <= matches_seen_next;
      escape_step    <= escape_step_next;
      high_nibble    <= high_nibble_next;
      emitted_any    <= emitted_any_next;
      escape_error   <= escape_error_next;
    end
  end

  a_escape_only_in_value: assert property (@(posedge clk) disable iff (rst)
    phase != PH_VALUE |-> escape_step == ESC_NONE)
    else $error("escape in progress outside a value");

  a_error_needs_emit: assert property (@(posedge clk) disable iff (rst)
    escape_error |-> emitted_any)
    else $error("escape error flagged without an emitted value");

  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    accept && in_data.end_of_string |=> phase == PH_KEY && matches_seen == 8'd0
      && !emitted_any && !escape_error)
    else $error("string state not cleared at end of string");

endmodule

@@ rtl/qpve_out_fifo.sv @@
// ----------------------------------------------------------------------------
// qpve_out_fifo
// Small result queue; takes up to two results a cycle, gives one when popped.
// ----------------------------------------------------------------------------
module qpve_out_fifo
  import qpve_pkg::*;
#(
  parameter int DEPTH = OUT_DEPTH_DEF
) (
  input  logic      clk,
  input  logic      rst,
  input  push_t     push,
  input  logic      pop,
  output logic      not_empty,
  output logic      room_for_two,
  output out_item_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR  = PW'(DEPTH - 1);
  localparam logic [CW-1:0] ROOM_MARK = CW'(DEPTH - 2);

  out_item_t     mem [DEPTH];
  logic [PW-1:0] wr_ptr, wr_ptr_next, wr_ptr_plus1;
  logic [PW-1:0] rd_ptr, rd_ptr_next;
  logic [CW-1:0] count, count_next;
  logic          do_pop;

  function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
    return (p == LAST_PTR) ? '0 : p + PW'(1);
  endfunction

  assign not_empty    = (count != '0);
  assign room_for_two = (count <= ROOM_MARK);
  assign head         = mem[rd_ptr];
  assign do_pop       = pop && not_empty;
  assign wr_ptr_plus1 = wrap_inc(wr_ptr);

  always_comb begin
    case (push.count)
      2'd1:    wr_ptr_next = wr_ptr_plus1;
      2'd2:    wr_ptr_next = wrap_inc(wr_ptr_plus1);
      default: wr_ptr_next = wr_ptr;
    endcase
    rd_ptr_next = do_pop ? wrap_inc(rd_ptr) : rd_ptr;
    count_next  = count + CW'(push.count) - CW'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem[wr_ptr] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem[wr_ptr_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
      count  <= count_next;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push.count != 2'd0 |-> room_for_two)
    else $error("result pushed without room");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(DEPTH))
    else $error("result queue count out of range");

endmodule

@@ rtl/query_parameter_value_extractor_unit.sv @@
// ----------------------------------------------------------------------------
// query_parameter_value_extractor_unit
// Extracts and URL-decodes the value of a configured key from a form-encoded
// query string, delivered one byte per transaction.
// ----------------------------------------------------------------------------
// Results: registered in the result queue, offered in order from its head.
// Throughput: one input byte per cycle; the ", " pair in all-instances mode
//   puts two results into the queue, and input stalls only while the queue
//   cannot take two more (it drains one result a cycle while out_stall is low).
// Reset: synchronous, active high; clears parser state and the result queue,
//   and sets key_text 0, key_length 1, instance_cfg 1.
// ----------------------------------------------------------------------------
module query_parameter_value_extractor_unit
  import qpve_pkg::*;
#(
  parameter int MAX_KEY_BYTES = MAX_KEY_BYTES_DEF,
  parameter int OUT_DEPTH     = OUT_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // input channel
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  // output channel
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  // configuration write port
  input  logic       write_enable,
  input  logic [1:0] reg_index,
  input  logic [63:0] write_data
);

  // Configuration registers; only the key bytes that can ever be compared
  // are kept.
  logic [8*MAX_KEY_BYTES-1:0] key_text;
  logic [3:0]                 key_length;
  logic [7:0]                 instance_cfg;

  logic  accept;
  logic  room_for_two;
  push_t push;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_text     <= '0;
      key_length   <= 4'd1;
      instance_cfg <= 8'd1;
    end else if (write_enable) begin
      case (reg_index)
        REG_KEY_TEXT:   key_text     <= write_data[8*MAX_KEY_BYTES-1:0];
        REG_KEY_LENGTH: key_length   <= write_data[3:0];
        REG_INSTANCE:   instance_cfg <= write_data[7:0];
        default: begin
          // index beyond the register list: drop the write
        end
      endcase
    end
  end

  // Hold input while the queue could not take the largest burst one
  // transaction can raise; the stall comes from registered state only.
  assign in_stall = !room_for_two;
  assign accept   = in_valid && !in_stall;

  qpve_parser #(
    .MAX_KEY_BYTES(MAX_KEY_BYTES)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .in_data     (in_data),
    .key_text    (key_text),
    .key_length  (key_length),
    .instance_cfg(instance_cfg),
    .push        (push)
  );

  // Results wait here, so input flows on while the output stalls and room lasts.
  qpve_out_fifo #(
    .DEPTH(OUT_DEPTH)
  ) u_out_fifo (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .pop         (!out_stall),
    .not_empty   (out_valid),
    .room_for_two(room_for_two),
    .head        (out_data)
  );

  a_stall_holds_result: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

@@ bench/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the query parameter value extractor. Query strings
// are fed one byte per transaction under several key and instance settings,
// while a scoreboard predicts every decoded byte, separator and final status
// and checks them in order against what the block returns.
// ----------------------------------------------------------------------------
module testbench
  import qpve_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  typedef logic [7:0] byte_q_t[$];

  // --------------------------------------------------------------------------
  // Scoreboard: holds its own copy of the parser state and registers, works out
  // what each accepted transaction must produce and checks results in order.
  // --------------------------------------------------------------------------
  class extract_scoreboard;
    logic [63:0]  key_text;
    logic [3:0]   key_length;
    logic [7:0]   instance_cfg;
    phase_t       phase;
    logic [3:0]   match_pos;
    logic [7:0]   matches_seen;
    escape_step_t esc;
    logic [3:0]   high_nibble;
    logic         emitted_any;
    logic         escape_error;
    out_item_t    pending_results[$];
    int           failures;

    function new();
      key_text     = '0;
      key_length   = 4'd1;
      instance_cfg = 8'd1;
      failures     = 0;
      clear_string();
    endfunction

    function void clear_string();
      phase        = PH_KEY;
      match_pos    = '0;
      matches_seen = '0;
      esc          = ESC_NONE;
      high_nibble  = '0;
      emitted_any  = 1'b0;
      escape_error = 1'b0;
    endfunction

    function void configure(logic [1:0] idx, logic [63:0] value);
      case (idx)
        REG_KEY_TEXT:   key_text = value;
        REG_KEY_LENGTH: key_length = value[3:0];
        REG_INSTANCE:   instance_cfg = value[7:0];
        default: ;
      endcase
    endfunction

    // Uppercase hex only; -1 for anything else
    function int digit_value(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) return int'(c) - int'(CH_ZERO);
      if (c >= CH_UPPER_A && c <= CH_UPPER_F) return int'(c) - int'(CH_UPPER_A) + 10;
      return -1;
    endfunction

    function void expect_item(logic [7:0] b, logic kind, logic [1:0] st, logic lst);
      out_item_t r;
      r.out_byte = b;
      r.out_kind = kind;
      r.status   = st;
      r.last     = lst;
      pending_results.push_back(r);
    endfunction

    function int pending();
      return pending_results.size();
    endfunction

    function void accept_input(in_item_t it);
      logic [7:0] c;
      logic [3:0] klen;
      logic       sel;
      int         d;
      c    = it.in_byte;
      klen = (key_length > 4'd8) ? 4'd8 : key_length;

      if (it.end_of_string) begin
        if (phase == PH_VALUE && esc != ESC_NONE) escape_error = 1'b1;
        expect_item(8'h00, KIND_STATUS,
                    escape_error ? ST_BAD_ESCAPE : (emitted_any ? ST_OK : ST_NOT_FOUND),
                    1'b1);
        clear_string();
        return;
      end

      if (c == CH_AMP) begin
        if (phase == PH_VALUE && esc != ESC_NONE) escape_error = 1'b1;
        phase     = PH_KEY;
        match_pos = '0;
        esc       = ESC_NONE;
        return;
      end

      case (phase)
        PH_KEY: begin
          if (match_pos < klen) begin
            if (c == key_text[{match_pos[2:0], 3'b000} +: 8]) match_pos = match_pos + 4'd1;
            else phase = PH_SKIP;
          end else if (c == CH_EQUALS) begin
            sel = 1'b0;
            if (instance_cfg == 8'd0) begin
              sel = 1'b1;
              if (matches_seen != 8'hFF) matches_seen = matches_seen + 8'd1;
            end else if (matches_seen != 8'hFF) begin
              matches_seen = matches_seen + 8'd1;
              sel = (matches_seen == instance_cfg);
            end
            if (sel) begin
              if (instance_cfg == 8'd0 && emitted_any) begin
                expect_item(CH_COMMA, KIND_BYTE, ST_OK, 1'b0);
                expect_item(CH_SPACE, KIND_BYTE, ST_OK, 1'b0);
              end
              emitted_any = 1'b1;
              phase       = PH_VALUE;
              esc         = ESC_NONE;
            end else begin
              phase = PH_SKIP;
            end
          end else begin
            phase = PH_SKIP;
          end
        end
        PH_VALUE: begin
          case (esc)
            ESC_HIGH: begin
              d = digit_value(c);
              if (d < 0) begin
                escape_error = 1'b1;
                esc = ESC_NONE;
              end else begin
                high_nibble = d[3:0];
                esc = ESC_LOW;
              end
            end
            ESC_LOW: begin
              d = digit_value(c);
              if (d < 0) escape_error = 1'b1;
              else expect_item({high_nibble, d[3:0]}, KIND_BYTE, ST_OK, 1'b0);
              esc = ESC_NONE;
            end
            default: begin
              if (c == CH_PERCENT) esc = ESC_HIGH;
              else if (c == CH_PLUS) expect_item(CH_SPACE, KIND_BYTE, ST_OK, 1'b0);
              else expect_item(c, KIND_BYTE, ST_OK, 1'b0);
            end
          endcase
        end
        default: ;
      endcase
    endfunction

    // Results are shown as byte/kind/status/last
    function void check_output(out_item_t got);
      out_item_t want;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none, got %02h/%0d/%0d/%0d",
                 $time, got.out_byte, got.out_kind, got.status, got.last);
        failures++;
        return;
      end
      want = pending_results.pop_front();
      if (got.out_byte !== want.out_byte || got.out_kind !== want.out_kind ||
          got.status !== want.status || got.last !== want.last) begin
        $display("%0t: mismatch, expected %02h/%0d/%0d/%0d, got %02h/%0d/%0d/%0d",
                 $time, want.out_byte, want.out_kind, want.status, want.last,
                 got.out_byte, got.out_kind, got.status, got.last);
        failures++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block under test
  // --------------------------------------------------------------------------
  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        write_enable = 1'b0;
  logic [1:0]  reg_index = REG_KEY_TEXT;
  logic [63:0] write_data = '0;

  always #5 clk = ~clk;

  query_parameter_value_extractor_unit dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_data     (out_data),
    .write_enable (write_enable),
    .reg_index    (reg_index),
    .write_data   (write_data)
  );

  extract_scoreboard sb = new();

  int          src_idle_pct  = 0;
  int          sink_idle_pct = 0;
  int          items_sent    = 0;
  logic [63:0] cur_key = '0;
  int          cur_len = 1;
  logic        sink_hold = 1'b0;
  event        start_hold;

  // --------------------------------------------------------------------------
  // Receiving side: check every transaction taken from the output channel, then
  // choose the stall for the next cycle. A long hold-off overrides the dice.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_output(out_data);
    out_stall <= sink_hold || ($urandom_range(0, 99) < sink_idle_pct);
  end

  // Hold the output for a long stretch, counted here, so the result queue fills
  // and the block has to stall its input.
  initial begin
    forever begin
      @(start_hold);
      sink_hold = 1'b1;
      repeat (60) @(posedge clk);
      sink_hold = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Sending side
  // --------------------------------------------------------------------------

  // Offer one transaction and wait until it is taken. Valid is left high so a
  // next item can go out back to back; it drops only while idling or draining.
  task automatic send_item(in_item_t it);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.accept_input(it);
    items_sent++;
  endtask

  // Drop valid and hold until every predicted result has come back, then give
  // transactions that raise no result time to settle as well.
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Send the query bytes, then the end-of-string transaction. The sender
  // pauses for a full drain before byte pause_at (none when negative).
  task automatic send_query(byte_q_t q, int pause_at);
    in_item_t it;
    foreach (q[i]) begin
      if (i == pause_at) drain_results();
      it.in_byte       = q[i];
      it.end_of_string = 1'b0;
      send_item(it);
    end
    it.in_byte       = 8'($urandom_range(0, 255));
    it.end_of_string = 1'b1;
    send_item(it);
  endtask

  // Write all three registers on consecutive edges; the block is idle here.
  task automatic program_key(logic [63:0] key, logic [3:0] len, logic [7:0] inst);
    write_enable <= 1'b1;
    reg_index    <= REG_KEY_TEXT;
    write_data   <= key;
    @(posedge clk);
    sb.configure(REG_KEY_TEXT, key);
    reg_index    <= REG_KEY_LENGTH;
    write_data   <= 64'(len);
    @(posedge clk);
    sb.configure(REG_KEY_LENGTH, 64'(len));
    reg_index    <= REG_INSTANCE;
    write_data   <= 64'(inst);
    @(posedge clk);
    sb.configure(REG_INSTANCE, 64'(inst));
    write_enable <= 1'b0;
    cur_key = key;
    cur_len = int'(len);
  endtask

  // --------------------------------------------------------------------------
  // Query string generation
  // --------------------------------------------------------------------------
  function automatic void append_text(ref byte_q_t q, input string s);
    for (int i = 0; i < s.len(); i++) q.push_back(s[i]);
  endfunction

  function automatic void append_key(ref byte_q_t q, input int n);
    for (int i = 0; i < n; i++) q.push_back(cur_key[8*i +: 8]);
  endfunction

  function automatic logic [7:0] hex_char(int n);
    return (n < 10) ? 8'(CH_ZERO + n) : 8'(CH_UPPER_A + n - 10);
  endfunction

  function automatic logic [7:0] lower_letter();
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  // Value made of plain letters, '+', good, bad and cut-short escapes, and the
  // odd arbitrary byte (which may well end the field).
  function automatic void add_value(ref byte_q_t q);
    int tokens;
    tokens = $urandom_range(0, 5);
    for (int t = 0; t < tokens; t++) begin
      case ($urandom_range(0, 9))
        0, 1, 2: q.push_back(lower_letter());
        3: q.push_back(CH_PLUS);
        4: begin
          q.push_back(CH_PERCENT);
          q.push_back(hex_char($urandom_range(0, 15)));
          q.push_back(hex_char($urandom_range(0, 15)));
        end
        5: begin
          q.push_back(CH_PERCENT);
          q.push_back(lower_letter());
        end
        6: begin
          q.push_back(CH_PERCENT);
          q.push_back(hex_char($urandom_range(0, 15)));
          q.push_back(lower_letter());
        end
        7: q.push_back(8'($urandom_range(0, 255)));
        8: q.push_back(CH_PERCENT);
        default: begin
          q.push_back(CH_PERCENT);
          q.push_back(hex_char($urandom_range(0, 15)));
        end
      endcase
    end
  endfunction

  function automatic void add_field(ref byte_q_t q);
    int klen;
    int idx;
    int n;
    klen = (cur_len > 8) ? 8 : cur_len;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        append_key(q, klen);
        q.push_back(CH_EQUALS);
        add_value(q);
      end
      5: begin
        // key with one bit flipped somewhere
        append_key(q, klen);
        if (klen > 0) begin
          idx = q.size() - 1 - $urandom_range(0, klen - 1);
          q[idx] = q[idx] ^ (8'h01 << $urandom_range(0, 7));
        end
        q.push_back(CH_EQUALS);
        add_value(q);
      end
      6: append_key(q, $urandom_range(0, klen));
      7: begin
        n = $urandom_range(1, 6);
        for (int i = 0; i < n; i++) q.push_back(8'($urandom_range(0, 255)));
      end
      8: ;
      default: begin
        // key followed by something other than '='
        append_key(q, klen);
        q.push_back(lower_letter());
        add_value(q);
      end
    endcase
  endfunction

  function automatic void build_query(ref byte_q_t q);
    int fields;
    q = {};
    fields = $urandom_range(1, 5);
    for (int f = 0; f < fields; f++) begin
      if (f > 0) q.push_back(CH_AMP);
      add_field(q);
    end
  endfunction

  task automatic random_queries(int count);
    byte_q_t q;
    int      start;
    start = items_sent;
    while (items_sent - start < count) begin
      build_query(q);
      send_query(q, -1);
    end
  endtask

  function automatic logic [63:0] random_word_key();
    logic [63:0] k;
    for (int i = 0; i < 8; i++) k[8*i +: 8] = lower_letter();
    return k;
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    byte_q_t q;

    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Sender idles now and then, receiver mostly stalls
    src_idle_pct  = 19;
    sink_idle_pct = 87;

    // Directed: all instances of "ab"; plus sign, escape, zero and all-ones
    // bytes, an empty value that still takes its separator, and an escape cut
    // short by the end of the string. Then an empty string: key not found.
    program_key({48'h0, "b", "a"}, 4'd2, 8'd0);
    q = {};
    append_text(q, "ab=+%4A");
    q.push_back(8'h00);
    q.push_back(8'hFF);
    append_text(q, "&ab=&ab=%4");
    send_query(q, -1);
    q = {};
    send_query(q, -1);
    random_queries(10);

    drain_results();
    program_key(64'({random_word_key() << 8, "q"}), 4'd1, 8'd2);
    random_queries(10);

    drain_results();
    program_key(random_word_key(), 4'd8, 8'd1);
    random_queries(10);

    // Swap the roles: sender mostly idle, receiver rarely stalls
    src_idle_pct  = 87;
    sink_idle_pct = 19;

    // Empty key: any field opening with '=' matches
    drain_results();
    program_key(random_word_key(), 4'd0, 8'd0);
    random_queries(10);

    // Ampersand inside the key can never match
    drain_results();
    program_key(64'({random_word_key() << 24, "y", "&", "x"}), 4'd3, 8'd0);
    random_queries(10);

    // Length beyond the key store is clipped to eight bytes
    drain_results();
    program_key(random_word_key(), 4'd15, 8'd3);
    random_queries(10);

    drain_results();
    program_key('1, 4'd8, 8'd0);
    random_queries(10);

    // No idling from here on
    src_idle_pct  = 0;
    sink_idle_pct = 0;

    // Long receiver hold-off while bytes keep coming, then a mid-string pause
    // until everything predicted has drained.
    drain_results();
    program_key(64'({random_word_key() << 8, "k"}), 4'd1, 8'd0);
    q = {};
    append_text(q, "k=abcdefghijklmnopqrstuvwxyz+0123456789&k=%41%42+%5A");
    -> start_hold;
    send_query(q, 30);

    drain_results();
    program_key({48'h0, "b", "a"}, 4'd2, 8'd1);
    random_queries(10);

    drain_results();
    repeat (8) @(posedge clk);
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Hard stop in case the block hangs
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
